// ----- hdl/fcull_pkg.sv -----
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants for the frustum box culler: matrix layout,
// plane widths, register indexes and verdict codes.
// ----------------------------------------------------------------------------
package fcull_pkg;

    // matrix layout: four rows of four signed Q3.12 entries
    localparam int NUM_ROWS     = 4;
    localparam int NUM_COLS     = 4;
    localparam int ENTRY_W      = 16;
    localparam int ROW_W        = NUM_ROWS * ENTRY_W;

    // planes: sum or difference of at most two entries, one bit of growth
    localparam int PLANE_W      = ENTRY_W + 1;
    localparam int NUM_PLANES   = 6;
    localparam int NUM_AXES     = 3;

    // offset scale from Q.12 to Q.20 to line up with the products
    localparam int OFFSET_SHIFT = 8;

    // configuration register indexes
    localparam int CFG_INDEX_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_ROW_3 = 3'd3;

    // identity matrix after reset
    localparam logic [ROW_W-1:0] MATRIX_ROW_0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] MATRIX_ROW_1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] MATRIX_ROW_2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] MATRIX_ROW_3_RESET = 64'h1000_0000_0000_0000;

    // verdict codes
    localparam int VERDICT_W = 2;
    localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd2;

    // plane order
    localparam int PLANE_LEFT   = 0;
    localparam int PLANE_RIGHT  = 1;
    localparam int PLANE_BOTTOM = 2;
    localparam int PLANE_TOP    = 3;
    localparam int PLANE_NEAR   = 4;
    localparam int PLANE_FAR    = 5;

    typedef logic signed [PLANE_W-1:0] plane_coef_t;
    typedef logic signed [ENTRY_W-1:0] matrix_entry_t;

endpackage

// ----- hdl/frustum_aabb_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// View-frustum test of axis-aligned boxes against six planes taken from a
// view-projection matrix; one verdict word per box word.
// ----------------------------------------------------------------------------
// Takes one box per clock while the output is not stalled and returns its
// verdict (inside, intersect or outside) in order, one result per box.
// The pipeline has five register stages: box capture, vertex select
// with 36 parallel multipliers (six planes, positive and negative vertex,
// three axes), a first adder level, the sign of the full plane distance, and
// the verdict output register. Each stage holds while the next one is full
// and stalled, so bubbles are squeezed out and a box is still taken while a
// finished verdict waits. Plane coefficients are registered from the matrix
// rows in the cycle after a write; write the matrix only with no box in flight.
module frustum_aabb_cull
    import fcull_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [ROW_W-1:0]              cfg_wdata,

    // box input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] s_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] s_box_min_z,
    input  logic signed [COORD_WIDTH-1:0] s_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] s_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] s_box_max_z,

    // verdict output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [VERDICT_W-1:0]          m_cull_verdict
);

    localparam int PROD_W = PLANE_W + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    // matrix row registers
    logic [ROW_W-1:0] matrix_reg [NUM_ROWS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg[0] <= MATRIX_ROW_0_RESET;
            matrix_reg[1] <= MATRIX_ROW_1_RESET;
            matrix_reg[2] <= MATRIX_ROW_2_RESET;
            matrix_reg[3] <= MATRIX_ROW_3_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MATRIX_ROW_0: matrix_reg[0] <= cfg_wdata;
                REG_MATRIX_ROW_1: matrix_reg[1] <= cfg_wdata;
                REG_MATRIX_ROW_2: matrix_reg[2] <= cfg_wdata;
                REG_MATRIX_ROW_3: matrix_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // plane extraction from rows
    plane_coef_t plane_next [NUM_PLANES][NUM_COLS];
    plane_coef_t plane_reg  [NUM_PLANES][NUM_COLS];

    always_comb begin
        plane_coef_t e0, e1, e2, e3;
        for (int c = 0; c < NUM_COLS; c++) begin
            e0 = PLANE_W'(matrix_entry_t'(matrix_reg[0][ENTRY_W*c +: ENTRY_W]));
            e1 = PLANE_W'(matrix_entry_t'(matrix_reg[1][ENTRY_W*c +: ENTRY_W]));
            e2 = PLANE_W'(matrix_entry_t'(matrix_reg[2][ENTRY_W*c +: ENTRY_W]));
            e3 = PLANE_W'(matrix_entry_t'(matrix_reg[3][ENTRY_W*c +: ENTRY_W]));
            plane_next[PLANE_LEFT][c]   = e3 + e0;
            plane_next[PLANE_RIGHT][c]  = e3 - e0;
            plane_next[PLANE_BOTTOM][c] = e3 + e1;
            plane_next[PLANE_TOP][c]    = e3 - e1;
            plane_next[PLANE_NEAR][c]   = e2;
            plane_next[PLANE_FAR][c]    = e3 - e2;
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg <= plane_next;
    end

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5     = !m_valid_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_valid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) v4_reg      <= v3_reg;
            if (en5) m_valid_reg <= v4_reg;
        end
    end

    // stage 1: box capture
    logic signed [COORD_WIDTH-1:0] lo1_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi1_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (en1) begin
            lo1_reg[0] <= s_box_min_x;
            lo1_reg[1] <= s_box_min_y;
            lo1_reg[2] <= s_box_min_z;
            hi1_reg[0] <= s_box_max_x;
            hi1_reg[1] <= s_box_max_y;
            hi1_reg[2] <= s_box_max_z;
        end
    end

    // stage 2: pick vertices by normal sign, multiply
    logic signed [COORD_WIDTH-1:0] sel_pos [NUM_PLANES][NUM_AXES];
    logic signed [COORD_WIDTH-1:0] sel_neg [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      prod_pos_reg [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      prod_neg_reg [NUM_PLANES][NUM_AXES];

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (!plane_reg[p][a][PLANE_W-1]) begin
                    sel_pos[p][a] = hi1_reg[a];
                    sel_neg[p][a] = lo1_reg[a];
                end else begin
                    sel_pos[p][a] = lo1_reg[a];
                    sel_neg[p][a] = hi1_reg[a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    prod_pos_reg[p][a] <= PROD_W'(plane_reg[p][a]) * PROD_W'(sel_pos[p][a]);
                    prod_neg_reg[p][a] <= PROD_W'(plane_reg[p][a]) * PROD_W'(sel_neg[p][a]);
                end
            end
        end
    end

    // stage 3: first adder level, offset scaled to the product format
    logic signed [SUM_W-1:0] offset    [NUM_PLANES];
    logic signed [SUM_W-1:0] pa_pos_reg [NUM_PLANES];
    logic signed [SUM_W-1:0] pb_pos_reg [NUM_PLANES];
    logic signed [SUM_W-1:0] pa_neg_reg [NUM_PLANES];
    logic signed [SUM_W-1:0] pb_neg_reg [NUM_PLANES];

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            offset[p] = SUM_W'(plane_reg[p][NUM_COLS-1]) <<< OFFSET_SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                pa_pos_reg[p] <= SUM_W'(prod_pos_reg[p][0]) + SUM_W'(prod_pos_reg[p][1]);
                pb_pos_reg[p] <= SUM_W'(prod_pos_reg[p][2]) + offset[p];
                pa_neg_reg[p] <= SUM_W'(prod_neg_reg[p][0]) + SUM_W'(prod_neg_reg[p][1]);
                pb_neg_reg[p] <= SUM_W'(prod_neg_reg[p][2]) + offset[p];
            end
        end
    end

    // stage 4: full distance, keep only whether the vertex is behind
    logic signed [SUM_W-1:0] dist_pos [NUM_PLANES];
    logic signed [SUM_W-1:0] dist_neg [NUM_PLANES];
    logic [NUM_PLANES-1:0]   behind_pos_reg;
    logic [NUM_PLANES-1:0]   behind_neg_reg;

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            dist_pos[p] = pa_pos_reg[p] + pb_pos_reg[p];
            dist_neg[p] = pa_neg_reg[p] + pb_neg_reg[p];
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                behind_pos_reg[p] <= dist_pos[p][SUM_W-1];
                behind_neg_reg[p] <= dist_neg[p][SUM_W-1];
            end
        end
    end

    // stage 5: verdict output register
    logic [VERDICT_W-1:0] verdict_next;
    logic [VERDICT_W-1:0] verdict_reg;

    always_comb begin
        if (|behind_pos_reg) begin
            verdict_next = VERDICT_OUTSIDE;
        end else if (|behind_neg_reg) begin
            verdict_next = VERDICT_INTERSECT;
        end else begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cull_verdict = verdict_reg;

endmodule

// ----- hdl/fcull_checker.sv -----
// ----------------------------------------------------------------------------
// fcull_checker
// Port-level checks on the frustum box culler, bound to the top level.
// ----------------------------------------------------------------------------
module fcull_checker
    import fcull_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [VERDICT_W-1:0] m_cull_verdict
);

    // no verdict word straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("verdict word valid right after reset");

    // a verdict word carries a defined code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cull_verdict == VERDICT_INSIDE ||
                     m_cull_verdict == VERDICT_INTERSECT ||
                     m_cull_verdict == VERDICT_OUTSIDE))
        else $error("undefined verdict code");

    // a stalled verdict word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cull_verdict))
        else $error("verdict word dropped or changed while stalled");

    // with the output empty the pipeline can always take a box
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("box input blocked with empty output");

    // with the sink ready no box waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && m_ready |-> s_ready)
        else $error("box input blocked with sink ready");

endmodule

bind frustum_aabb_cull fcull_checker u_fcull_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_cull_verdict (m_cull_verdict)
);
